FILE: design/tiny_vm_cpu_step_defines.svh
// Assertion macros for the VM step block
`ifndef TINY_VM_CPU_STEP_DEFINES_SVH
`define TINY_VM_CPU_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define TVM_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define TVM_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TVM_ASSERT_IMPL(lbl, clk, rstn, a, c)
`define TVM_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

FILE: design/tvm_pkg.sv
package tvm_pkg;
  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [4:0] OPC_NOP = 5'h00;
  localparam logic [4:0] OPC_ALU = 5'h01;
  localparam logic [4:0] OPC_LDI = 5'h02;

  localparam logic [7:0] SUB_NOP  = 8'h00;
  localparam logic [7:0] SUB_SYS  = 8'h01;
  localparam logic [7:0] SUB_LOAD = 8'h02;
  localparam logic [7:0] SUB_STOR = 8'h03;
  localparam logic [7:0] SUB_EQ   = 8'h04;
  localparam logic [7:0] SUB_GT   = 8'h05;
  localparam logic [7:0] SUB_LT   = 8'h06;
  localparam logic [7:0] SUB_ADD  = 8'h07;
  localparam logic [7:0] SUB_SUB  = 8'h08;

  localparam logic [7:0] SYS_NOP  = 8'h00;
  localparam logic [7:0] SYS_IMM  = 8'h02;
  localparam logic [7:0] SYS_REG  = 8'h03;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_addr;
    logic [31:0] write_word;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_word;
    logic [15:0] pc_now;
    logic        cond_flag;
    logic        in_interrupt;
    logic [15:0] return_pc;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_FWAIT, S_REGA, S_REGB, S_EXEC, S_MEMW, S_PCRD, S_PCWR,
    S_RDW, S_CLR, S_DONE
  } state_t;
endpackage

FILE: design/tvm_if.sv
interface tvm_cmd_if import tvm_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tvm_res_if import tvm_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/tvm_front.sv
// Input stage plus two-entry command queue
module tvm_front import tvm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tvm_cmd_if.sink    cin,
  output logic       q_valid,
  output cmd_t       q_data,
  input  logic       q_pop
);
  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign cin.ready = (cnt_r != 2'd2);
  assign push      = cin.valid && cin.ready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_data    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= cin.data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: design/tvm_back.sv
// Executes commands; register file and word memory are synchronous RAMs
module tvm_back import tvm_pkg::*; #(
  parameter int ADDR_BITS    = 16,
  parameter int PC_INDEX     = 255,
  parameter int CODE_INDEX   = 254,
  parameter int INVALID_CODE = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] int_vector,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        res_valid,
  output res_t        res_data,
  input  logic        res_ready
);
  localparam logic [7:0] PCI = 8'(PC_INDEX);
  localparam logic [7:0] CDI = 8'(CODE_INDEX);
  localparam logic [7:0] INV = 8'(INVALID_CODE);

  logic [31:0] mem [2**ADDR_BITS];
  logic [31:0] rf  [256];
  logic [255:0] rf_vld_r;

  state_t state_r, state_nxt;
  cmd_t   cur_r;
  logic [31:0] ins_r, a_r, rdat_r, pc_r;
  logic        flag_r, int_r, ok_r;
  logic [15:0] spc_r;

  // memory port
  logic                 m_we;
  logic [ADDR_BITS-1:0] m_addr;
  logic [31:0]          m_wd, m_q_r;
  // register file port
  logic        r_we;
  logic [7:0]  r_addr;
  logic [31:0] r_wd, r_q_raw, r_q;
  logic        r_vq_r;
  logic [31:0] b_op;

  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wd;
    m_q_r <= mem[m_addr];
    if (r_we) rf[r_addr] <= r_wd;
    r_q_raw <= rf[r_addr];
  end
  assign r_q = r_vq_r ? r_q_raw : 32'd0;
  // rb operand: the read issued in S_REGB lands in S_EXEC
  assign b_op = r_q;

  logic [2:0] pred;
  logic [4:0] opc;
  logic [7:0] sub, ra, rb;
  logic pfail, trap;
  logic [7:0] code;
  assign pred = ins_r[31:29];
  assign opc  = ins_r[28:24];
  assign sub  = ins_r[23:16];
  assign ra   = ins_r[15:8];
  assign rb   = ins_r[7:0];
  assign pfail = (pred == 3'd1 && !int_r) || (pred == 3'd2 && !flag_r) ||
                 (pred == 3'd3 && flag_r);

  always_comb begin
    trap = 1'b0;
    code = INV;
    if (pred > 3'd3) trap = 1'b1;
    else if (pfail || opc == OPC_NOP || opc == OPC_LDI) trap = 1'b0;
    else if (opc == OPC_ALU) begin
      unique case (sub)
        SUB_NOP, SUB_LOAD, SUB_STOR, SUB_EQ, SUB_GT, SUB_LT, SUB_ADD, SUB_SUB: trap = 1'b0;
        SUB_SYS: begin
          if (ra == SYS_IMM) begin trap = 1'b1; code = rb; end
          else if (ra == SYS_REG) begin trap = 1'b1; code = b_op[7:0]; end
          else trap = (ra != SYS_NOP);
        end
        default: trap = 1'b1;
      endcase
    end else trap = 1'b1;
  end

  logic live;
  assign live = !pfail && pred <= 3'd3;

  // step: FETCH(read pc) FWAIT(read mem) REGA REGB EXEC (+MEMW for load)
  // PCRD re-reads pc after a possible write, PCWR writes pc+1 or vector.
  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    m_we = 1'b0; m_addr = cur_r.mem_addr[ADDR_BITS-1:0]; m_wd = cur_r.write_word;
    r_we = 1'b0; r_addr = PCI; r_wd = 32'd0;
    unique case (state_r)
      S_IDLE: begin
        // start the read early so S_RDW sees the word
        m_addr = q_data.mem_addr[ADDR_BITS-1:0];
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_data.cmd)
            CMD_STEP:  state_nxt = S_FETCH;
            CMD_WRITE: state_nxt = S_MEMW;
            CMD_READ:  state_nxt = S_RDW;
            default:   state_nxt = S_CLR;
          endcase
        end
      end
      S_FETCH: begin r_addr = PCI; state_nxt = S_FWAIT; end
      S_FWAIT: begin m_addr = r_q[ADDR_BITS-1:0]; r_addr = PCI; state_nxt = S_REGA; end
      S_REGA: begin r_addr = m_q_r[15:8]; state_nxt = S_REGB; end
      S_REGB: begin r_addr = ins_r[7:0]; state_nxt = S_EXEC; end
      S_EXEC: begin
        state_nxt = S_PCRD;
        m_addr = b_op[ADDR_BITS-1:0];
        if (trap) begin
          if (int_r) state_nxt = S_DONE;
          else begin r_we = 1'b1; r_addr = CDI; r_wd = {24'd0, code}; end
        end else if (live && opc == OPC_LDI) begin
          r_we = 1'b1; r_addr = sub; r_wd = {16'd0, ins_r[15:0]};
        end else if (live && opc == OPC_ALU) begin
          unique case (sub)
            SUB_LOAD: state_nxt = S_MEMW;
            SUB_STOR: begin m_we = 1'b1; m_wd = a_r; end
            SUB_ADD: begin r_we = 1'b1; r_addr = ra; r_wd = a_r + b_op; end
            SUB_SUB: begin r_we = 1'b1; r_addr = ra; r_wd = a_r - b_op; end
            default: ;
          endcase
        end
      end
      S_MEMW: begin
        if (cur_r.cmd == CMD_WRITE) begin m_we = 1'b1; state_nxt = S_DONE; end
        else begin r_we = 1'b1; r_addr = ra; r_wd = m_q_r; state_nxt = S_PCRD; end
      end
      S_PCRD: begin r_addr = PCI; state_nxt = S_PCWR; end
      S_PCWR: begin
        r_we = 1'b1; r_addr = PCI;
        r_wd = trap ? {16'd0, int_vector} : {16'd0, r_q[15:0] + 16'd1};
        state_nxt = S_DONE;
      end
      S_RDW: state_nxt = S_DONE;
      S_CLR: state_nxt = S_DONE;
      S_DONE: if (!res_valid) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin cur_r <= q_data; ok_r <= 1'b1; rdat_r <= 32'd0; end
    if (state_r == S_REGA) ins_r <= m_q_r;
    if (state_r == S_REGB) a_r <= r_q;
    if (state_r == S_RDW) rdat_r <= m_q_r;
    if (state_r == S_DONE && !res_valid)
      res_data <= '{ok_r, rdat_r, pc_r[15:0], flag_r, int_r, spc_r};
    if (!rst_n) begin
      state_r <= S_IDLE; rf_vld_r <= '0; r_vq_r <= 1'b0; pc_r <= 32'd0;
      flag_r <= 1'b0; int_r <= 1'b0; spc_r <= 16'd0; res_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      r_vq_r <= rf_vld_r[r_addr];
      if (r_we) rf_vld_r[r_addr] <= 1'b1;
      if (state_r == S_CLR) int_r <= 1'b0;
      if (state_r == S_FWAIT) pc_r <= r_q;
      if (state_r == S_EXEC) begin
        if (trap && int_r) ok_r <= 1'b0;
        else if (trap) begin int_r <= 1'b1; spc_r <= pc_r[15:0]; end
        else if (live && opc == OPC_ALU) begin
          if (sub == SUB_EQ) flag_r <= (a_r == b_op);
          if (sub == SUB_GT) flag_r <= (a_r > b_op);
          if (sub == SUB_LT) flag_r <= (a_r < b_op);
        end
      end
      if (state_r == S_PCWR) pc_r <= r_wd;
      if (state_r == S_DONE && !res_valid) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
    end
  end
endmodule

FILE: design/tiny_vm_cpu_step.sv
// Tiny VM step engine.
// cin carries commands (cmd, mem_addr, write_word); one result per command
// leaves on rout (ok, read_word, pc_now, cond_flag, in_interrupt, return_pc).
// cfg_we/cfg_wdata set the interrupt vector; write it only while idle.
// A two-entry queue takes commands while the executor works, so the
// sender can run ahead. An instruction step walks the states FETCH to
// PCWR (plus MEMW for a load; a trap taken while in interrupt ends after
// EXEC), set by the single-port register file read in sequence (PC,
// fetch, operands, write-back, PC update).
// The result sits in an output register; while the receiver stalls the
// executor waits in its final state and the queue keeps filling.
// Reset (synchronous, rst_n low) clears registers at once via per-register
// valid bits, plus flags, saved PC and vector; memory is undefined.
module tiny_vm_cpu_step import tvm_pkg::*; #(
  parameter int ADDR_BITS    = 16,
  parameter int PC_INDEX     = 255,
  parameter int CODE_INDEX   = 254,
  parameter int INVALID_CODE = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  tvm_cmd_if.sink     cin,
  tvm_res_if.source   rout,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
`include "tiny_vm_cpu_step_defines.svh"
  logic [15:0] vec_r;
  logic q_valid, q_pop;
  cmd_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) vec_r <= 16'd0;
    else if (cfg_we) vec_r <= cfg_wdata;
  end

  tvm_front u_front (.clk, .rst_n, .cin, .q_valid, .q_data, .q_pop);

  tvm_back #(.ADDR_BITS(ADDR_BITS), .PC_INDEX(PC_INDEX), .CODE_INDEX(CODE_INDEX),
             .INVALID_CODE(INVALID_CODE)) u_back (
    .clk, .rst_n, .int_vector(vec_r), .q_valid, .q_data, .q_pop,
    .res_valid(rout.valid), .res_data(rout.data), .res_ready(rout.ready));

  `TVM_ASSERT_IMPL(a_pop_has_item, clk, rst_n, q_pop, q_valid)
  `TVM_ASSERT_NEXT(a_out_hold, clk, rst_n, rout.valid && !rout.ready, rout.valid)
endmodule

FILE: tb/sv/tvm_tb_pkg.sv
package tvm_tb_pkg;
  import tvm_pkg::*;

  // Bit-accurate model of the VM; one result per command.
  class vm_scoreboard;
    logic [31:0] regs [256];
    logic [31:0] mem [int unsigned];
    bit flag;
    bit in_int;
    logic [15:0] saved_pc;
    logic [15:0] vector;
    res_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < 256; i++) regs[i] = '0;
      flag = 0;
      in_int = 0;
      saved_pc = '0;
      vector = '0;
      errors = 0;
    endfunction

    function logic [31:0] mem_rd(logic [15:0] a);
      if (mem.exists(a)) return mem[a];
      return '0;
    endfunction

    // Returns 0 on a trap taken while already in interrupt.
    function bit exec_insn();
      logic [31:0] pc, ins, a, b;
      logic [2:0] pred;
      logic [4:0] opc;
      logic [7:0] sub, ra, rb, code;
      bit trap;
      pc = regs[255];
      ins = mem_rd(pc[15:0]);
      pred = ins[31:29];
      opc = ins[28:24];
      sub = ins[23:16];
      ra = ins[15:8];
      rb = ins[7:0];
      code = 8'hFF;
      trap = 0;
      a = regs[ra];
      b = regs[rb];
      if (pred > 3) begin
        trap = 1;
      end else if ((pred == 1 && !in_int) || (pred == 2 && !flag) || (pred == 3 && flag)) begin
      end else if (opc == OPC_NOP) begin
      end else if (opc == OPC_LDI) begin
        regs[sub] = {16'h0, ins[15:0]};
      end else if (opc == OPC_ALU) begin
        case (sub)
          SUB_NOP: ;
          SUB_LOAD: regs[ra] = mem_rd(b[15:0]);
          SUB_STOR: mem[b[15:0]] = a;
          SUB_EQ: flag = (a == b);
          SUB_GT: flag = (a > b);
          SUB_LT: flag = (a < b);
          SUB_ADD: regs[ra] = a + b;
          SUB_SUB: regs[ra] = a - b;
          SUB_SYS: begin
            if (ra == SYS_NOP) begin
            end else if (ra == SYS_IMM) begin
              trap = 1;
              code = rb;
            end else if (ra == SYS_REG) begin
              trap = 1;
              code = b[7:0];
            end else begin
              trap = 1;
            end
          end
          default: trap = 1;
        endcase
      end else begin
        trap = 1;
      end
      if (!trap) begin
        regs[255] = {16'h0, regs[255][15:0] + 16'd1};
        return 1;
      end
      if (in_int) return 0;
      saved_pc = pc[15:0];
      regs[255] = {16'h0, vector};
      regs[254] = {24'h0, code};
      in_int = 1;
      return 1;
    endfunction

    function void note_command(cmd_t c);
      res_t r;
      r.ok = 1;
      r.read_word = '0;
      case (c.cmd)
        CMD_STEP: r.ok = exec_insn();
        CMD_WRITE: mem[c.mem_addr] = c.write_word;
        CMD_READ: r.read_word = mem_rd(c.mem_addr);
        default: in_int = 0;
      endcase
      r.pc_now = regs[255][15:0];
      r.cond_flag = flag;
      r.in_interrupt = in_int;
      r.return_pc = saved_pc;
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.ok !== exp.ok)
        $display("%0t: ok exp %0d got %0d", $time, exp.ok, got.ok);
      if (got.read_word !== exp.read_word)
        $display("%0t: read_word exp %h got %h", $time, exp.read_word, got.read_word);
      if (got.pc_now !== exp.pc_now)
        $display("%0t: pc_now exp %h got %h", $time, exp.pc_now, got.pc_now);
      if (got.cond_flag !== exp.cond_flag)
        $display("%0t: cond_flag exp %0d got %0d", $time, exp.cond_flag, got.cond_flag);
      if (got.in_interrupt !== exp.in_interrupt)
        $display("%0t: in_interrupt exp %0d got %0d", $time, exp.in_interrupt,
                 got.in_interrupt);
      if (got.return_pc !== exp.return_pc)
        $display("%0t: return_pc exp %h got %h", $time, exp.return_pc, got.return_pc);
      if (got !== exp) errors++;
    endfunction
  endclass
endpackage

FILE: tb/sv/tiny_vm_cpu_step_tb.sv
module tiny_vm_cpu_step_tb;
  import tvm_pkg::*;
  import tvm_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  tvm_cmd_if cin();
  tvm_res_if rout();

  tiny_vm_cpu_step uut (
    .clk(clk), .rst_n(rst_n), .cin(cin.sink), .rout(rout.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  vm_scoreboard sb;
  int cycles;
  bit send_idle_on;
  bit recv_idle_on;
  int recv_hold;
  bit [15:0] written[$];  // addresses holding known data

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && cin.valid && cin.ready) sb.note_command(cin.data);
    if (rst_n && rout.valid && rout.ready) sb.check_result(rout.data);
  end

  // Receiver: random bursts of stall, or a long forced hold.
  initial begin
    int n;
    rout.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        rout.ready <= 0;
        recv_hold--;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        rout.ready <= 0;
        repeat (n - 1) @(negedge clk);
      end else begin
        rout.ready <= 1;
      end
    end
  end

  // valid stays high on return; the next send or drain replaces or drops it
  task automatic send(cmd_t c);
    int n;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      cin.valid <= 0;
      repeat (n) @(negedge clk);
    end
    cin.data <= c;
    cin.valid <= 1;
    @(posedge clk);
    while (!cin.ready) @(posedge clk);
    @(negedge clk);
    if (c.cmd == CMD_WRITE) written.push_back(c.mem_addr);
  endtask

  task automatic mem_write(logic [15:0] a, logic [31:0] w);
    cmd_t c;
    c.cmd = CMD_WRITE;
    c.mem_addr = a;
    c.write_word = w;
    send(c);
  endtask

  task automatic issue(logic [1:0] k, logic [15:0] a);
    cmd_t c;
    c.cmd = k;
    c.mem_addr = a;
    c.write_word = $urandom;
    send(c);
  endtask

  // Place an instruction at the model's current PC and step it.
  task automatic run_insn(logic [31:0] ins);
    mem_write(sb.regs[255][15:0], ins);
    issue(CMD_STEP, 16'($urandom));
  endtask

  task automatic drain();
    cin.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_vector(logic [15:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    sb.vector = v;
  endtask

  function automatic logic [7:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return 8'd255;
      1: return 8'd254;
      default: return 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [31:0] rand_insn();
    logic [31:0] ins;
    logic [2:0] pred;
    pred = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3));
    ins = $urandom;
    case ($urandom_range(0, 9))
      0: ins[28:24] = OPC_NOP;
      1, 2: begin
        ins[28:24] = OPC_LDI;
        ins[23:16] = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 7));
      end
      3: ins[28:24] = 5'($urandom_range(3, 31));
      default: begin
        ins[28:24] = OPC_ALU;
        ins[23:16] = 8'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8));
        ins[15:8] = pick_reg();
        ins[7:0] = pick_reg();
        if (ins[23:16] == SUB_SYS) ins[15:8] = 8'($urandom_range(0, 4));
      end
    endcase
    ins[31:29] = pred;
    return ins;
  endfunction

  // True if a step now would read only memory that holds known data.
  function automatic bit step_safe(logic [31:0] ins);
    logic [31:0] b;
    b = sb.regs[ins[7:0]];
    if (ins[28:24] == OPC_ALU && ins[23:16] == SUB_LOAD) begin
      foreach (written[i]) if (written[i] == b[15:0]) return 1;
      return 0;
    end
    return 1;
  endfunction

  initial begin
    cmd_t c;
    logic [31:0] ins;
    int k;
    sb = new();
    cycles = 0;
    send_idle_on = 0;
    recv_idle_on = 0;
    recv_hold = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    cin.valid = 0;
    cin.data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed
    mem_write(16'hFFFF, 32'hFFFF_FFFF);
    mem_write(16'h0000, 32'h0000_0000);
    issue(CMD_READ, 16'hFFFF);
    issue(CMD_READ, 16'h0000);
    run_insn({3'd0, OPC_LDI, 8'd1, 16'hFFFF});
    run_insn({3'd0, OPC_LDI, 8'd2, 16'h0001});
    run_insn({3'd0, OPC_ALU, SUB_ADD, 8'd1, 8'd2});
    run_insn({3'd0, OPC_ALU, SUB_SUB, 8'd3, 8'd2});
    run_insn({3'd0, OPC_ALU, SUB_EQ, 8'd1, 8'd1});
    run_insn({3'd0, OPC_ALU, SUB_GT, 8'd3, 8'd2});
    run_insn({3'd2, OPC_ALU, SUB_LT, 8'd2, 8'd3});
    run_insn({3'd3, OPC_ALU, SUB_STOR, 8'd1, 8'd2});
    run_insn({3'd0, OPC_ALU, SUB_STOR, 8'd3, 8'd2});
    run_insn({3'd0, OPC_ALU, SUB_LOAD, 8'd4, 8'd2});
    run_insn({3'd1, OPC_NOP, 24'h0});
    run_insn({3'd0, OPC_ALU, SUB_SYS, SYS_IMM, 8'h5A});
    run_insn({3'd1, OPC_ALU, SUB_SYS, SYS_REG, 8'd3});  // double trap
    issue(CMD_CLEAR, 16'h0);
    set_vector(16'hFFFF);
    run_insn({3'd7, 29'h1FFF_FFFF});
    issue(CMD_CLEAR, 16'h0);
    run_insn({3'd0, OPC_LDI, 8'd255, 16'hFFFF});
    run_insn({3'd0, OPC_ALU, SUB_SYS, SYS_NOP, 8'h00});
    run_insn({3'd0, 5'h1F, 24'hFFFFFF});

    // random
    send_idle_on = 1;
    recv_idle_on = 1;
    for (k = 0; k < 375; k++) begin
      if (k == 90) begin
        recv_hold = 300;  // long receiver stall; queue fills up
      end
      if (k == 180) begin
        drain();  // sender pause
        set_vector(16'($urandom));
      end
      if (k == 270) set_vector(16'h0000);
      if (k == 330) begin
        set_vector(16'($urandom));
        send_idle_on = 0;
        recv_idle_on = 0;
      end
      case ($urandom_range(0, 9))
        0: begin
          c.cmd = CMD_WRITE;
          c.mem_addr = 16'($urandom);
          c.write_word = $urandom;
          send(c);
        end
        1: begin
          if (written.size() != 0)
            issue(CMD_READ, written[$urandom_range(0, written.size() - 1)]);
        end
        2: issue(CMD_CLEAR, 16'($urandom));
        default: begin
          ins = rand_insn();
          if (step_safe(ins)) run_insn(ins);
        end
      endcase
    end

    drain();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
